// ===== hw/rtl/wavhdr_pkg.sv =====
// wavhdr_pkg: shared types and constants for the WAV header byte parser.
// Holds the word structs, status codes, header step codes and tag values.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package wavhdr_pkg;

  // Result status reported with each output word
  typedef enum logic [3:0] {
    ST_PARSING       = 4'd0,
    ST_DONE          = 4'd1,
    ST_PAYLOAD       = 4'd2,
    ST_BAD_RIFF      = 4'd3,
    ST_BAD_WAVE      = 4'd4,
    ST_BAD_FMT       = 4'd5,
    ST_BAD_FMT_SIZE  = 4'd6,
    ST_NOT_PCM       = 4'd7,
    ST_BAD_CHANNELS  = 4'd8,
    ST_BAD_RATE      = 4'd9,
    ST_BAD_BITS      = 4'd10,
    ST_BAD_DATA_TAG  = 4'd11
  } status_t;

  // Header field currently being read
  typedef enum logic [3:0] {
    STEP_RIFF_TAG    = 4'd0,
    STEP_RIFF_SIZE   = 4'd1,
    STEP_WAVE_TAG    = 4'd2,
    STEP_FMT_TAG     = 4'd3,
    STEP_FMT_SIZE    = 4'd4,
    STEP_FORMAT      = 4'd5,
    STEP_CHANNELS    = 4'd6,
    STEP_RATE        = 4'd7,
    STEP_BYTE_RATE   = 4'd8,
    STEP_BLOCK_ALIGN = 4'd9,
    STEP_SAMPLE_BITS = 4'd10,
    STEP_CHUNK_TAG   = 4'd11,
    STEP_LIST_SIZE   = 4'd12,
    STEP_SKIP        = 4'd13,
    STEP_DATA_TAG    = 4'd14,
    STEP_DATA_SIZE   = 4'd15
  } step_t;

  // Configuration register indexes
  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t CFG_RATE        = 2'd0;
  localparam cfg_index_t CFG_CHANNELS    = 2'd1;
  localparam cfg_index_t CFG_SAMPLE_BITS = 2'd2;

  localparam logic [31:0] RATE_RESET        = 32'd44100;
  localparam logic [15:0] CHANNELS_RESET    = 16'd1;
  localparam logic [15:0] SAMPLE_BITS_RESET = 16'd16;

  // Four-character tags, first character in the low byte
  localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
  localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
  localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
  localparam logic [31:0] TAG_LIST = 32'h5453_494c;
  localparam logic [31:0] TAG_DATA = 32'h6174_6164;

  localparam logic [31:0] FMT_SIZE_PCM = 32'd16;
  localparam logic [31:0] FORMAT_PCM   = 32'd1;

  // Accepted input word
  typedef struct packed {
    logic       restart;
    logic [7:0] byte_value;
  } in_word_t;

  // Result word
  typedef struct packed {
    logic [31:0] data_bytes;
    logic [31:0] header_bytes;
    status_t     status;
  } result_t;

  // Index of the last byte of the field read at a step
  function automatic logic [1:0] field_last(input step_t step);
    case (step)
      STEP_FORMAT, STEP_CHANNELS, STEP_BLOCK_ALIGN, STEP_SAMPLE_BITS: field_last = 2'd1;
      default: field_last = 2'd3;
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/wavhdr_in_reg.sv =====
// wavhdr_in_reg: input register that holds one accepted byte word.
// Depends on wavhdr_pkg for the word type.
`timescale 1ns / 1ps
`default_nettype none

module wavhdr_in_reg (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_ready,
  input  wire wavhdr_pkg::in_word_t in_word,
  output logic                      held_valid,
  input  wire logic                 take,
  output wavhdr_pkg::in_word_t      held_word
);
  import wavhdr_pkg::*;

  // Free when empty or when the held word moves on this cycle
  assign in_ready = !held_valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ready) begin
      held_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      held_word <= in_word;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wavhdr_core.sv =====
// wavhdr_core: configuration registers, parse state and per-byte header checks.
// Depends on wavhdr_pkg for steps, status codes, tags and word types.
`timescale 1ns / 1ps
`default_nettype none

module wavhdr_core (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   cfg_we,
  input  wire wavhdr_pkg::cfg_index_t cfg_index,
  input  wire logic [31:0]            cfg_data,
  input  wire logic                   fire,
  input  wire wavhdr_pkg::in_word_t   word,
  output wavhdr_pkg::result_t         result
);
  import wavhdr_pkg::*;

  // Configuration
  logic [31:0] expected_rate;
  logic [15:0] expected_channels;
  logic [15:0] expected_sample_bits;

  // Parse state
  step_t       step;
  logic [1:0]  byte_in_field;
  logic [31:0] gather;
  logic [31:0] skip_left;
  logic [31:0] byte_count;
  status_t     held_status;
  logic [31:0] data_length;

  // State as seen by this byte (cleared on restart)
  step_t       cur_step;
  logic [1:0]  cur_bif;
  logic [31:0] cur_gather;
  logic [31:0] cur_skip;
  logic [31:0] cur_count;
  status_t     cur_held;
  logic [31:0] cur_dlen;

  // Field assembly and check
  logic [31:0] gathered;
  logic        field_end;
  status_t     check;
  step_t       step_next;
  logic [31:0] skip_left_next;
  logic [31:0] data_length_next;

  // Other next values
  logic [1:0]  byte_in_field_next;
  logic [31:0] gather_next;
  logic [31:0] byte_count_next;
  status_t     held_status_next;
  logic [31:0] skip_dec;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_rate        <= RATE_RESET;
      expected_channels    <= CHANNELS_RESET;
      expected_sample_bits <= SAMPLE_BITS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_RATE:        expected_rate        <= cfg_data;
        CFG_CHANNELS:    expected_channels    <= cfg_data[15:0];
        CFG_SAMPLE_BITS: expected_sample_bits <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // Restart clears the state before the byte is parsed
  always_comb begin
    if (word.restart) begin
      cur_step   = STEP_RIFF_TAG;
      cur_bif    = 2'd0;
      cur_gather = 32'd0;
      cur_skip   = 32'd0;
      cur_count  = 32'd0;
      cur_held   = ST_PARSING;
      cur_dlen   = 32'd0;
    end else begin
      cur_step   = step;
      cur_bif    = byte_in_field;
      cur_gather = gather;
      cur_skip   = skip_left;
      cur_count  = byte_count;
      cur_held   = held_status;
      cur_dlen   = data_length;
    end
  end

  // Next step: assemble the field and check it when its last byte arrives
  always_comb begin
    gathered = cur_gather;
    gathered[{cur_bif, 3'b000} +: 8] = word.byte_value;
    field_end        = (cur_bif == field_last(cur_step));
    skip_dec         = cur_skip - 32'd1;
    check            = ST_PARSING;
    step_next        = cur_step;
    skip_left_next   = cur_skip;
    data_length_next = cur_dlen;
    if (cur_held == ST_PARSING) begin
      if (cur_step == STEP_SKIP) begin
        skip_left_next = skip_dec;
        if (skip_dec == 32'd0) step_next = STEP_DATA_TAG;
      end else if (field_end) begin
        step_next = step_t'(cur_step + 4'd1);
        case (cur_step)
          STEP_RIFF_TAG:    if (gathered != TAG_RIFF) check = ST_BAD_RIFF;
          STEP_WAVE_TAG:    if (gathered != TAG_WAVE) check = ST_BAD_WAVE;
          STEP_FMT_TAG:     if (gathered != TAG_FMT) check = ST_BAD_FMT;
          STEP_FMT_SIZE:    if (gathered != FMT_SIZE_PCM) check = ST_BAD_FMT_SIZE;
          STEP_FORMAT:      if (gathered != FORMAT_PCM) check = ST_NOT_PCM;
          STEP_CHANNELS:    if (gathered != {16'd0, expected_channels}) check = ST_BAD_CHANNELS;
          STEP_RATE:        if (gathered != expected_rate) check = ST_BAD_RATE;
          STEP_SAMPLE_BITS: if (gathered != {16'd0, expected_sample_bits}) check = ST_BAD_BITS;
          STEP_CHUNK_TAG: begin
            if (gathered == TAG_LIST) step_next = STEP_LIST_SIZE;
            else if (gathered == TAG_DATA) step_next = STEP_DATA_SIZE;
            else check = ST_BAD_DATA_TAG;
          end
          STEP_LIST_SIZE: begin
            skip_left_next = gathered;
            step_next = (gathered != 32'd0) ? STEP_SKIP : STEP_DATA_TAG;
          end
          STEP_DATA_TAG:    if (gathered != TAG_DATA) check = ST_BAD_DATA_TAG;
          STEP_DATA_SIZE: begin
            data_length_next = gathered;
            check = ST_DONE;
            step_next = STEP_DATA_SIZE;
          end
          default: ;
        endcase
      end
    end
  end

  // Outputs and remaining next values
  always_comb begin
    byte_in_field_next = cur_bif;
    gather_next        = cur_gather;
    byte_count_next    = cur_count;
    held_status_next   = cur_held;
    if (cur_held != ST_PARSING) begin
      if (cur_held == ST_DONE) held_status_next = ST_PAYLOAD;
    end else begin
      if (cur_count != 32'hFFFF_FFFF) byte_count_next = cur_count + 32'd1;
      if (cur_step != STEP_SKIP) begin
        if (field_end) begin
          byte_in_field_next = 2'd0;
          gather_next        = 32'd0;
          held_status_next   = check;
        end else begin
          byte_in_field_next = cur_bif + 2'd1;
          gather_next        = gathered;
        end
      end
    end
    result.status       = held_status_next;
    result.header_bytes = byte_count_next;
    result.data_bytes   = data_length_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step          <= STEP_RIFF_TAG;
      byte_in_field <= 2'd0;
      gather        <= 32'd0;
      skip_left     <= 32'd0;
      byte_count    <= 32'd0;
      held_status   <= ST_PARSING;
      data_length   <= 32'd0;
    end else if (fire) begin
      step          <= step_next;
      byte_in_field <= byte_in_field_next;
      gather        <= gather_next;
      skip_left     <= skip_left_next;
      byte_count    <= byte_count_next;
      held_status   <= held_status_next;
      data_length   <= data_length_next;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wavhdr_out_reg.sv =====
// wavhdr_out_reg: result register feeding the output stream.
// Depends on wavhdr_pkg for the result type.
`timescale 1ns / 1ps
`default_nettype none

module wavhdr_out_reg (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                res_valid,
  output logic                     take,
  input  wire wavhdr_pkg::result_t res,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output wavhdr_pkg::result_t      out_word
);
  import wavhdr_pkg::*;

  // Loads when empty or when the current word leaves
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (take && res_valid) begin
      out_word <= res;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/wav_header_byte_parser.sv =====
// wav_header_byte_parser: top level of the WAV header byte parser.
// Depends on wavhdr_pkg, wavhdr_in_reg, wavhdr_core and wavhdr_out_reg.
//
//   channel  direction  handshake          payload
//   s_*      in         s_tvalid/s_tready  byte_value in s_tdata, restart in s_tuser
//   m_*      out        m_tvalid/m_tready  header_bytes, data_bytes in m_tdata; status in m_tuser
//   cfg_*    in         cfg_we             register index and write data
//
// One byte word per cycle sustained while m_tready stays high; a result word is offered on
// m_tvalid after its byte is accepted into the input register and the check logic then
// loads the result register; an output stall holds the byte in the input register.
// Synchronous reset clears both registers' valid flags and the parse state, and loads
// the expected format registers with 44100 Hz, 1 channel, 16 bits.
// An output stall fills the result register and then the input register, after which
// s_tready drops.
`timescale 1ns / 1ps
`default_nettype none

module wav_header_byte_parser (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   s_tvalid,
  output logic                        s_tready,
  input  wire logic [7:0]             s_tdata,   // [7:0] byte_value
  input  wire logic                   s_tuser,   // [0] restart
  output logic                        m_tvalid,
  input  wire logic                   m_tready,
  output logic [63:0]                 m_tdata,   // [31:0] header_bytes, [63:32] data_bytes
  output logic [3:0]                  m_tuser,   // [3:0] status
  input  wire logic                   cfg_we,
  input  wire wavhdr_pkg::cfg_index_t cfg_index,
  input  wire logic [31:0]            cfg_data
);
  import wavhdr_pkg::*;

  in_word_t in_word;
  in_word_t held_word;
  logic     held_valid;
  logic     take;
  logic     fire;
  result_t  res;
  result_t  out_word;

  assign in_word.byte_value = s_tdata;
  assign in_word.restart    = s_tuser;
  assign fire               = held_valid && take;

  wavhdr_in_reg u_in (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_word    (in_word),
    .held_valid (held_valid),
    .take       (take),
    .held_word  (held_word)
  );

  wavhdr_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .fire      (fire),
    .word      (held_word),
    .result    (res)
  );

  wavhdr_out_reg u_out (
    .clk       (clk),
    .rst       (rst),
    .res_valid (held_valid),
    .take      (take),
    .res       (res),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_word  (out_word)
  );

  assign m_tdata = {out_word.data_bytes, out_word.header_bytes};
  assign m_tuser = out_word.status;

endmodule

`default_nettype wire

// ===== hw/rtl/wavhdr_checker.sv =====
// wavhdr_checker: port-level assertions for wav_header_byte_parser, bound to the top.
// Tracks words in flight; no package dependency.
`timescale 1ns / 1ps
`default_nettype none

module wavhdr_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [63:0] m_tdata,
  input wire logic [3:0]  m_tuser
);

  // Words accepted but not yet delivered
  logic [1:0] in_flight;
  logic       acc;
  logic       dlv;

  assign acc = s_tvalid && s_tready;
  assign dlv = m_tvalid && m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_flight <= 2'd0;
    end else begin
      in_flight <= in_flight + {1'b0, acc} - {1'b0, dlv};
    end
  end

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output valid after reset");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled output word changed");

  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    in_flight == 2'd0 |-> !m_tvalid)
    else $error("output word with nothing accepted");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    in_flight == 2'd2 && !m_tready |-> !s_tready && in_flight != 2'd3)
    else $error("input taken while both registers full");

endmodule

bind wav_header_byte_parser wavhdr_checker u_wavhdr_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);

`default_nettype wire

// ===== tb/sv/tb_wav_header_byte_parser.sv =====
// tb_wav_header_byte_parser: self-checking bench for the WAV header byte parser.
// Builds WAV headers (good, flawed, cut short) and random byte noise, predicts each status word.
// Depends on wavhdr_pkg and wav_header_byte_parser.
`timescale 1ns / 1ps

module tb_wav_header_byte_parser;
  import wavhdr_pkg::*;

  localparam int CYCLE_LIMIT = 500000;
  localparam int HOLD_CYCLES = 100;

  // Header field that a flawed file gets a damaged byte in
  typedef enum int {
    FLAW_NONE, FLAW_RIFF, FLAW_WAVE, FLAW_FMT, FLAW_FMT_SIZE, FLAW_FORMAT,
    FLAW_CHANNELS, FLAW_RATE, FLAW_BITS, FLAW_CHUNK_TAG, FLAW_DATA_TAG
  } flaw_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'd0;   // [7:0] byte_value
  logic        s_tuser = 1'b0;   // [0] restart
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [63:0] m_tdata;          // [31:0] header_bytes, [63:32] data_bytes
  logic [3:0]  m_tuser;          // [3:0] status
  logic        cfg_we = 1'b0;
  cfg_index_t  cfg_index = CFG_RATE;
  logic [31:0] cfg_data = 32'd0;

  wav_header_byte_parser u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  in_word_t    pending_bytes[$];
  result_t     expected_words[$];
  logic [7:0]  file_bytes[$];
  int          pushed = 0;
  int          n_fail = 0;
  int          cycles = 0;
  bit          quiet = 1'b0;
  bit          hold_req = 1'b0;
  int          hold_left = 0;
  int          tx_gap = 0;
  int          rx_gap = 0;

  // Parser state as the block should hold it
  logic [31:0] want_rate = RATE_RESET;
  logic [15:0] want_chan = CHANNELS_RESET;
  logic [15:0] want_bits = SAMPLE_BITS_RESET;
  step_t       p_step;
  logic [1:0]  p_idx;
  logic [31:0] p_gather;
  logic [31:0] p_skip;
  logic [31:0] p_count;
  status_t     p_held;
  logic [31:0] p_len;

  function void clear_parse();
    p_step = STEP_RIFF_TAG;
    p_idx = 2'd0;
    p_gather = 32'd0;
    p_skip = 32'd0;
    p_count = 32'd0;
    p_held = ST_PARSING;
    p_len = 32'd0;
  endfunction

  // Advance the parser by one byte and return the status word it gives
  function automatic result_t parse_byte(input logic restart, input logic [7:0] b);
    result_t     r;
    logic [31:0] v;
    logic [2:0]  flen;
    step_t       nxt;
    status_t     st;
    if (restart) clear_parse();
    r.status = ST_PARSING;
    if (p_held != ST_PARSING) begin
      // done or error: byte ignored, sizes frozen
      if (p_held == ST_DONE) p_held = ST_PAYLOAD;
      r.status = p_held;
    end else begin
      if (p_count != 32'hFFFF_FFFF) p_count = p_count + 32'd1;
      if (p_step == STEP_SKIP) begin
        p_skip = p_skip - 32'd1;
        if (p_skip == 32'd0) p_step = STEP_DATA_TAG;
      end else begin
        flen = (p_step inside {STEP_FORMAT, STEP_CHANNELS, STEP_BLOCK_ALIGN,
                               STEP_SAMPLE_BITS}) ? 3'd2 : 3'd4;
        p_gather = p_gather | ({24'd0, b} << (8 * p_idx));
        if (({1'b0, p_idx} + 3'd1) >= flen) begin
          v = p_gather;
          p_gather = 32'd0;
          p_idx = 2'd0;
          nxt = step_t'(p_step + 4'd1);
          st = ST_PARSING;
          case (p_step)
            STEP_RIFF_TAG:    if (v != TAG_RIFF) st = ST_BAD_RIFF;
            STEP_WAVE_TAG:    if (v != TAG_WAVE) st = ST_BAD_WAVE;
            STEP_FMT_TAG:     if (v != TAG_FMT) st = ST_BAD_FMT;
            STEP_FMT_SIZE:    if (v != FMT_SIZE_PCM) st = ST_BAD_FMT_SIZE;
            STEP_FORMAT:      if (v != FORMAT_PCM) st = ST_NOT_PCM;
            STEP_CHANNELS:    if (v != {16'd0, want_chan}) st = ST_BAD_CHANNELS;
            STEP_RATE:        if (v != want_rate) st = ST_BAD_RATE;
            STEP_SAMPLE_BITS: if (v != {16'd0, want_bits}) st = ST_BAD_BITS;
            STEP_CHUNK_TAG: begin
              if (v == TAG_LIST) nxt = STEP_LIST_SIZE;
              else if (v == TAG_DATA) nxt = STEP_DATA_SIZE;
              else st = ST_BAD_DATA_TAG;
            end
            STEP_LIST_SIZE: begin
              p_skip = v;
              nxt = (v != 32'd0) ? STEP_SKIP : STEP_DATA_TAG;
            end
            STEP_DATA_TAG:    if (v != TAG_DATA) st = ST_BAD_DATA_TAG;
            STEP_DATA_SIZE: begin
              p_len = v;
              st = ST_DONE;
            end
            default: ;
          endcase
          p_step = nxt;
          p_held = st;
          r.status = st;
        end else begin
          p_idx = p_idx + 2'd1;
        end
      end
    end
    r.header_bytes = p_count;
    r.data_bytes = p_len;
    return r;
  endfunction

  // Sender: predicts each accepted word, then offers the next pending byte
  always @(posedge clk) begin : drv
    in_word_t w;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) expected_words.push_back(parse_byte(s_tuser, s_tdata));
      if (!s_tvalid || s_tready) begin
        if (tx_gap > 0) begin
          tx_gap--;
          s_tvalid <= 1'b0;
        end else if (pending_bytes.size() > 0) begin
          w = pending_bytes.pop_front();
          s_tdata <= w.byte_value;
          s_tuser <= w.restart;
          s_tvalid <= 1'b1;
          if (!quiet && $urandom_range(0, 15) == 0) tx_gap = $urandom_range(1, 19);
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Receiver: checks each result word, stalls in bursts or one long hold
  always @(posedge clk) begin : mon
    result_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_words.size() == 0) begin
          $error("result word with none expected: status %0d, tdata %h", m_tuser, m_tdata);
          n_fail++;
        end else begin
          want = expected_words.pop_front();
          if (m_tuser !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, m_tuser);
            n_fail++;
          end
          if (m_tdata[31:0] !== want.header_bytes) begin
            $error("header_bytes: expected %0d, got %0d", want.header_bytes, m_tdata[31:0]);
            n_fail++;
          end
          if (m_tdata[63:32] !== want.data_bytes) begin
            $error("data_bytes: expected %0d, got %0d", want.data_bytes, m_tdata[63:32]);
            n_fail++;
          end
        end
      end
      if (hold_req) begin
        hold_left = HOLD_CYCLES;
        hold_req = 1'b0;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_tready <= 1'b0;
      end else if (rx_gap > 0) begin
        rx_gap--;
        m_tready <= 1'b0;
      end else begin
        m_tready <= 1'b1;
        if (!quiet && $urandom_range(0, 11) == 0) rx_gap = $urandom_range(1, 19);
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  task automatic push_word(input logic [7:0] b, input logic restart);
    in_word_t w;
    w.byte_value = b;
    w.restart = restart;
    pending_bytes.push_back(w);
    pushed++;
  endtask

  task automatic put_le(input logic [31:0] val, input int n);
    for (int k = 0; k < n; k++) file_bytes.push_back(val[8*k +: 8]);
  endtask

  // One WAV file: optional LIST chunk, optional damaged field, payload tail, cut at keep
  task automatic queue_file(input logic rs, input flaw_t flaw, input int list_len,
                            input bit big_list, input int tail, input int keep);
    int o;
    int n;
    int data_off;
    file_bytes.delete();
    put_le(TAG_RIFF, 4);
    put_le($urandom, 4);
    put_le(TAG_WAVE, 4);
    put_le(TAG_FMT, 4);
    put_le(FMT_SIZE_PCM, 4);
    put_le(FORMAT_PCM, 2);
    put_le({16'd0, want_chan}, 2);
    put_le(want_rate, 4);
    put_le($urandom, 4);
    put_le($urandom, 2);
    put_le({16'd0, want_bits}, 2);
    if (list_len >= 0) begin
      put_le(TAG_LIST, 4);
      // a huge length leaves the parser skipping until the next restart
      put_le(big_list ? ($urandom | 32'h100) : list_len, 4);
      repeat (list_len) put_le($urandom, 1);
    end
    data_off = file_bytes.size();
    put_le(TAG_DATA, 4);
    put_le($urandom, 4);
    repeat (tail) put_le($urandom, 1);
    o = -1;
    n = 4;
    case (flaw)
      FLAW_RIFF:      o = 0;
      FLAW_WAVE:      o = 8;
      FLAW_FMT:       o = 12;
      FLAW_FMT_SIZE:  o = 16;
      FLAW_FORMAT:    begin o = 20; n = 2; end
      FLAW_CHANNELS:  begin o = 22; n = 2; end
      FLAW_RATE:      o = 24;
      FLAW_BITS:      begin o = 34; n = 2; end
      FLAW_CHUNK_TAG: o = 36;
      FLAW_DATA_TAG:  o = data_off;
      default: ;
    endcase
    if (o >= 0) begin
      o = o + $urandom_range(0, n - 1);
      file_bytes[o] = file_bytes[o] ^ 8'($urandom_range(1, 255));
    end
    for (int i = 0; i < file_bytes.size() && i < keep; i++)
      push_word(file_bytes[i], (i == 0) ? rs : 1'b0);
  endtask

  // Mostly well-formed files with random content, some flawed, cut or noisy
  task automatic random_files(input int target);
    int    n0;
    int    r;
    flaw_t flaw;
    int    list_len;
    n0 = pushed;
    while (pushed - n0 < target) begin
      r = $urandom_range(0, 99);
      if (r < 8) begin
        repeat ($urandom_range(1, 6)) push_word(8'($urandom), $urandom_range(0, 7) == 0);
      end else begin
        flaw = (r < 40) ? flaw_t'($urandom_range(FLAW_RIFF, FLAW_DATA_TAG)) : FLAW_NONE;
        list_len = ($urandom_range(0, 1) == 0) ? -1 : $urandom_range(0, 5);
        queue_file($urandom_range(0, 9) != 0, flaw, list_len, $urandom_range(0, 11) == 0,
                   $urandom_range(0, 6), (r < 16) ? $urandom_range(1, 48) : 1000);
      end
    end
  endtask

  // Block idle: nothing queued, nothing offered, every result back
  task automatic wait_idle();
    do @(negedge clk);
    while (pending_bytes.size() != 0 || s_tvalid || expected_words.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [31:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    case (idx)
      CFG_RATE:        want_rate = val;
      CFG_CHANNELS:    want_chan = val[15:0];
      CFG_SAMPLE_BITS: want_bits = val[15:0];
      default: ;
    endcase
  endtask

  task automatic set_format(input logic [31:0] rate, input logic [31:0] chan,
                            input logic [31:0] bits);
    wait_idle();
    write_reg(CFG_RATE, rate);
    write_reg(CFG_CHANNELS, chan);
    write_reg(CFG_SAMPLE_BITS, bits);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clear_parse();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Directed: no restart after reset with a bad RIFF tag and ignored bytes after it,
    // then a file with an empty LIST body and two payload bytes
    queue_file(1'b0, FLAW_RIFF, -1, 1'b0, 0, 6);
    queue_file(1'b1, FLAW_NONE, 0, 1'b0, 2, 1000);

    // Lowest register values
    set_format(32'd0, 32'd0, 32'd0);
    random_files(400);

    // Highest register values; long receiver hold while the sender keeps offering
    set_format(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    hold_req = 1'b1;
    random_files(400);

    set_format($urandom, $urandom, $urandom);
    random_files(400);

    // Typical format, junk in the unused upper bits; no idling to the end
    set_format(32'd48000, 32'hABCD_0002, 32'h5A5A_0018);
    quiet = 1'b1;
    random_files(400);

    wait_idle();
    repeat (8) @(posedge clk);
    if (n_fail == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
